// File: rtl/mat4_vector_transform_assert.svh
// Assertion macros shared by the matrix-vector transform RTL.
`ifndef MAT4_VECTOR_TRANSFORM_ASSERT_SVH
`define MAT4_VECTOR_TRANSFORM_ASSERT_SVH

`ifndef SYNTHESIS
// Clocked property check, disabled while reset is asserted.
`define MVT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
// Condition that must never be seen out of reset.
`define MVT_ASSERT_NEVER(lbl, expr) `MVT_ASSERT(lbl, !(expr))
`else
`define MVT_ASSERT(lbl, prop)
`define MVT_ASSERT_NEVER(lbl, expr)
`endif

`endif

// File: rtl/mvt_pkg.sv
// Shared types and constants of the matrix-vector transform unit.
`default_nettype none

package mvt_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int COMP_W     = 32;
  localparam int PROD_W     = 2 * COMP_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int NUM_COMP   = 4;
  localparam int NUM_CFG    = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef comp_t [NUM_COMP-1:0]     vec_arr_t;
  typedef prod_t [NUM_COMP-1:0]     prod_arr_t;
  typedef acc_t  [NUM_COMP-1:0]     acc_arr_t;
  typedef logic [CFG_DATA_W-1:0]    cfg_word_t;
  typedef cfg_word_t [NUM_CFG-1:0]  cfg_arr_t;

  // Input item as it travels on the input channel.
  typedef struct packed {
    logic signed [COMP_W-1:0] vec_x;
    logic signed [COMP_W-1:0] vec_y;
    logic signed [COMP_W-1:0] vec_z;
    logic signed [COMP_W-1:0] vec_w;
    logic                     point_mode;
  } in_t;

  // Result item as it travels on the result channel.
  typedef struct packed {
    logic signed [COMP_W-1:0] out_x;
    logic signed [COMP_W-1:0] out_y;
    logic signed [COMP_W-1:0] out_z;
    logic signed [COMP_W-1:0] out_w;
    logic                     saturated;
  } out_t;

  // Data handed from one column cell to the next.
  typedef struct packed {
    logic     point;
    vec_arr_t vec;
    acc_arr_t acc;
  } cell_data_t;

  // Reset contents of the coefficient registers: the identity matrix.
  localparam cfg_arr_t CFG_RESET = '{
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000
  };

endpackage

`default_nettype wire

// File: rtl/mvt_col_cell.sv
// One column cell: multiplies one vector component by a matrix column and accumulates.
`default_nettype none

module mvt_col_cell
  import mvt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  input  wire cell_data_t up_data,
  output logic            up_stall,
  output logic            dn_valid,
  output cell_data_t      dn_data,
  input  wire logic       dn_stall,
  input  wire vec_arr_t   coef_col
);

  logic       a_valid_r;
  cell_data_t a_data_r;
  cell_data_t a_data_nxt;
  prod_arr_t  a_prod_r;
  prod_arr_t  a_prod_nxt;
  logic       b_valid_r;
  cell_data_t b_data_r;
  cell_data_t b_data_nxt;
  logic       a_load;
  logic       b_load;

  // Each stage loads when it is empty or its content moves on.
  assign b_load   = !b_valid_r || !dn_stall;
  assign a_load   = !a_valid_r || b_load;
  assign up_stall = !a_load;

  // Product stage: the leading component times each row coefficient.
  // The vector moves down one place so the next cell sees its own component first.
  always_comb begin
    a_data_nxt.point = up_data.point;
    a_data_nxt.acc   = up_data.acc;
    for (int i = 0; i < NUM_COMP - 1; i++) begin
      a_data_nxt.vec[i] = up_data.vec[i+1];
    end
    a_data_nxt.vec[NUM_COMP-1] = '0;
    for (int r = 0; r < NUM_COMP; r++) begin
      a_prod_nxt[r] = prod_t'(up_data.vec[0]) * prod_t'(coef_col[r]);
    end
  end

  // Accumulate stage: add each product to its row's running sum.
  always_comb begin
    b_data_nxt.point = a_data_r.point;
    b_data_nxt.vec   = a_data_r.vec;
    for (int r = 0; r < NUM_COMP; r++) begin
      b_data_nxt.acc[r] = $signed(a_data_r.acc[r])
                        + $signed({{(ACC_W-PROD_W){a_prod_r[r][PROD_W-1]}}, a_prod_r[r]});
    end
  end

  // Stage occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_load) begin
        a_valid_r <= up_valid;
      end
      if (b_load) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (a_load && up_valid) begin
      a_data_r <= a_data_nxt;
      a_prod_r <= a_prod_nxt;
    end
    if (b_load && a_valid_r) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_data  = b_data_r;

endmodule

`default_nettype wire

// File: rtl/mvt_sat_stage.sv
// Output stage: scales the row sums back to Q16.16, saturates and holds the result.
`default_nettype none

module mvt_sat_stage
  import mvt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  input  wire cell_data_t up_data,
  output logic            up_stall,
  output logic            out_valid,
  output out_t            out_data,
  input  wire logic       out_stall
);

  logic                    out_valid_r;
  out_t                    out_data_r;
  out_t                    out_data_nxt;
  logic                    load;
  acc_t                    shifted;
  logic [NUM_COMP-1:0]     clamp;
  comp_t [NUM_COMP-1:0]    comp;

  assign load     = !out_valid_r || !out_stall;
  assign up_stall = !load;

  // Floor shift of each sum, then clamp to the signed 32-bit range.
  always_comb begin
    shifted = '0;
    for (int r = 0; r < NUM_COMP; r++) begin
      shifted  = $signed(up_data.acc[r]) >>> FRAC_BITS;
      clamp[r] = !((&shifted[ACC_W-1:COMP_W-1]) || !(|shifted[ACC_W-1:COMP_W-1]));
      if (clamp[r]) begin
        comp[r] = shifted[ACC_W-1] ? {1'b1, {(COMP_W-1){1'b0}}} : {1'b0, {(COMP_W-1){1'b1}}};
      end else begin
        comp[r] = shifted[COMP_W-1:0];
      end
    end
    // In point mode the fourth row is not reported.
    out_data_nxt.out_x     = comp[0];
    out_data_nxt.out_y     = comp[1];
    out_data_nxt.out_z     = comp[2];
    out_data_nxt.out_w     = up_data.point ? '0 : comp[3];
    out_data_nxt.saturated = (|clamp[NUM_COMP-2:0]) || (clamp[NUM_COMP-1] && !up_data.point);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && up_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/mat4_vector_transform.sv
// Top level of the 4x4 matrix-vector transform unit.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data): one Q16.16 vector per transfer,
//   with point_mode selecting w = 1.0 and a zero w result.
//   Result channel (out_valid, out_stall, out_data): the transformed vector,
//   each component floor-shifted by 16 and clamped, plus a saturation flag.
//   Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): writes one of
//   eight 64-bit coefficient registers; cfg_ready is always high and indexes
//   above seven are ignored. Write only while no item is in flight.
// Pipeline: nine register stages, two in each of four column cells and the
//   output register, the first of them loaded by the input transfer itself.
// Throughput: one vector per cycle unless a result stall holds the chain; every cell
//   holds four 32x32 multipliers and a product register, so a new item can enter each cycle.
// Reset: clears all pipeline occupancy and loads the identity matrix.
// Stall: a stalled result holds in the output register; items behind it keep
//   moving into empty stages, and in_stall rises only once the chain is full.
`default_nettype none

module mat4_vector_transform
  import mvt_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

`include "mat4_vector_transform_assert.svh"

  cfg_arr_t                  cfg_r;
  cfg_arr_t                  cfg_nxt;
  vec_arr_t [NUM_COMP-1:0]   coef_col;
  logic [NUM_COMP:0]         chain_valid;
  logic [NUM_COMP:0]         chain_stall;
  cell_data_t [NUM_COMP:0]   chain_data;

  // Coefficient registers: a transfer on the config port replaces one word.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_CFG))) begin
      cfg_nxt[cfg_index[$clog2(NUM_CFG)-1:0]] = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Column c of the matrix: m[r][c] sits in word 2r + c/2, half c%2.
  for (genvar c = 0; c < NUM_COMP; c++) begin : g_col
    for (genvar r = 0; r < NUM_COMP; r++) begin : g_row
      assign coef_col[c][r] = cfg_r[2*r + (c >> 1)][(c & 1)*COMP_W +: COMP_W];
    end
  end

  // Chain entry: substitute w = 1.0 for points and start from zero sums.
  assign chain_valid[0]       = in_valid;
  assign in_stall             = chain_stall[0];
  assign chain_data[0].point  = in_data.point_mode;
  assign chain_data[0].vec[0] = in_data.vec_x;
  assign chain_data[0].vec[1] = in_data.vec_y;
  assign chain_data[0].vec[2] = in_data.vec_z;
  assign chain_data[0].vec[3] = in_data.point_mode ? (comp_t'(1) <<< FRAC_BITS) : in_data.vec_w;
  assign chain_data[0].acc    = '0;

  // One cell per matrix column.
  for (genvar c = 0; c < NUM_COMP; c++) begin : g_cell
    mvt_col_cell u_col (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[c]),
      .up_data  (chain_data[c]),
      .up_stall (chain_stall[c]),
      .dn_valid (chain_valid[c+1]),
      .dn_data  (chain_data[c+1]),
      .dn_stall (chain_stall[c+1]),
      .coef_col (coef_col[c])
    );
  end

  // Scaling, saturation and the result register.
  mvt_sat_stage u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (chain_valid[NUM_COMP]),
    .up_data   (chain_data[NUM_COMP]),
    .up_stall  (chain_stall[NUM_COMP]),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  // With the result register empty the whole chain can move, so input is taken.
  `MVT_ASSERT_NEVER(a_empty_out_no_stall, !out_valid && in_stall)
  // A config transfer to register zero lands in the coefficient store.
  `MVT_ASSERT(a_cfg_write, (cfg_valid && cfg_ready && cfg_index == '0) |=> (cfg_r[0] == $past(cfg_data)))
  // A point item leaving the chain produces a zero w result.
  `MVT_ASSERT(a_point_w_zero, (chain_valid[NUM_COMP] && !chain_stall[NUM_COMP] && chain_data[NUM_COMP].point) |=> (out_data.out_w == '0))

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the 4x4 matrix-vector transform unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mvt_pkg::*;

  localparam int RUN_LIMIT     = 400000;
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 160;
  localparam int REPORT_LIMIT  = 10;

  localparam logic signed [ACC_W-1:0] COMP_MAX = 66'sd2147483647;
  localparam logic signed [ACC_W-1:0] COMP_MIN = -66'sd2147483648;

  localparam comp_t Q_MAX  = 32'sh7FFF_FFFF;
  localparam comp_t Q_MIN  = 32'sh8000_0000;
  localparam comp_t Q_ONE  = 32'sh0001_0000;
  localparam comp_t Q_NEG1 = 32'shFFFF_FFFF;
  localparam comp_t Q_LSB  = 32'sh0000_0001;
  localparam comp_t Q_ZERO = 32'sh0000_0000;

  // How random coefficients and vector components are drawn.
  typedef enum int {
    STYLE_SMALL,
    STYLE_FULL,
    STYLE_EXTREME,
    STYLE_MIXED
  } value_style_e;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Vectors waiting to be driven and transformed vectors waiting to come out.
  in_t      vertex_q[$];
  out_t     transformed_q[$];
  cfg_arr_t matrix_regs;
  out_t     want;

  int cycle_count    = 0;
  int queued_total   = 0;
  int accepted_total = 0;
  int checked_total  = 0;
  int sat_total      = 0;
  int point_total    = 0;
  int cfg_writes     = 0;
  int mismatches     = 0;
  int in_gap         = 0;
  int stall_left     = 0;
  bit in_took        = 1'b0;
  bit in_idle_on     = 1'b0;
  bit out_idle_on    = 1'b0;

  mat4_vector_transform i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Exact row-times-vector sums, floor-shifted and clamped to 32 bits.
  function automatic out_t transform_vertex(input in_t item);
    logic signed [ACC_W-1:0] vin [NUM_COMP];
    logic signed [ACC_W-1:0] coef;
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] shifted;
    logic [CFG_DATA_W-1:0]   word;
    comp_t                   res [NUM_COMP];
    int                      rows;
    out_t                    o;
    o = '0;
    vin[0] = ACC_W'(item.vec_x);
    vin[1] = ACC_W'(item.vec_y);
    vin[2] = ACC_W'(item.vec_z);
    if (item.point_mode) begin
      vin[3] = ACC_W'(comp_t'(1) <<< FRAC_BITS);
    end else begin
      vin[3] = ACC_W'(item.vec_w);
    end
    for (int r = 0; r < NUM_COMP; r++) begin
      res[r] = '0;
    end
    // In point mode the w row is neither computed nor allowed to flag.
    rows = item.point_mode ? 3 : 4;
    for (int r = 0; r < rows; r++) begin
      sum = '0;
      for (int c = 0; c < NUM_COMP; c++) begin
        word = matrix_regs[2 * r + c / 2];
        if (c % 2 == 1) begin
          coef = ACC_W'($signed(word[63:32]));
        end else begin
          coef = ACC_W'($signed(word[31:0]));
        end
        sum = sum + coef * vin[c];
      end
      shifted = sum >>> FRAC_BITS;
      if (shifted > COMP_MAX) begin
        res[r] = Q_MAX;
        o.saturated = 1'b1;
      end else if (shifted < COMP_MIN) begin
        res[r] = Q_MIN;
        o.saturated = 1'b1;
      end else begin
        res[r] = shifted[31:0];
      end
    end
    o.out_x = res[0];
    o.out_y = res[1];
    o.out_z = res[2];
    o.out_w = res[3];
    return o;
  endfunction

  function automatic logic [31:0] random_value(input value_style_e style);
    int v;
    value_style_e pick;
    pick = style;
    if (pick == STYLE_MIXED) begin
      pick = value_style_e'($urandom_range(0, 2));
    end
    case (pick)
      STYLE_SMALL: begin
        // Within about eight units either side of zero.
        v = int'($urandom_range(0, 1 << 20)) - (1 << 19);
        return v[31:0];
      end
      STYLE_FULL: begin
        return $urandom;
      end
      default: begin
        case ($urandom_range(0, 6))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return Q_ZERO;
          3: return Q_LSB;
          4: return Q_NEG1;
          5: return Q_ONE;
          default: return -Q_ONE;
        endcase
      end
    endcase
  endfunction

  task automatic show_mismatch(input out_t exp_item, input out_t got_item);
    $display("mismatch at cycle %0d on result %0d", cycle_count, checked_total);
    $display("  expected x=%h y=%h z=%h w=%h sat=%b", exp_item.out_x, exp_item.out_y,
             exp_item.out_z, exp_item.out_w, exp_item.saturated);
    $display("  actual   x=%h y=%h z=%h w=%h sat=%b", got_item.out_x, got_item.out_y,
             got_item.out_z, got_item.out_w, got_item.saturated);
  endtask

  // One register write; the shadow matrix follows only in-range indexes.
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx < NUM_CFG) begin
      matrix_regs[idx] = val;
    end
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_row(input int r, input comp_t c0, input comp_t c1,
                         input comp_t c2, input comp_t c3);
    write_cfg(CFG_IDX_W'(2 * r), {c1, c0});
    write_cfg(CFG_IDX_W'(2 * r + 1), {c3, c2});
  endtask

  task automatic load_matrix(input value_style_e style);
    for (int i = 0; i < NUM_CFG; i++) begin
      write_cfg(CFG_IDX_W'(i), {random_value(style), random_value(style)});
    end
    // Writes above the last register must leave the matrix alone.
    if ($urandom_range(0, 1) == 1) begin
      write_cfg(CFG_IDX_W'($urandom_range(NUM_CFG, (1 << CFG_IDX_W) - 1)),
                {$urandom, $urandom});
    end
  endtask

  task automatic send(input comp_t x, input comp_t y, input comp_t z, input comp_t w,
                      input logic pm);
    in_t item;
    item.vec_x = x;
    item.vec_y = y;
    item.vec_z = z;
    item.vec_w = w;
    item.point_mode = pm;
    vertex_q.push_back(item);
    queued_total++;
  endtask

  // Every vector gives one result, so the pipeline is empty once all are back.
  task automatic wait_idle();
    while (accepted_total != queued_total || transformed_q.size() != 0) @(negedge clk);
  endtask

  // Input driver: holds a stalled transfer, otherwise sends or idles in bursts.
  always @(negedge clk) begin
    if (in_valid && !in_took) begin
      in_valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (vertex_q.size() != 0) begin
      if (in_idle_on && $urandom_range(0, 9) == 0) begin
        in_gap = $urandom_range(0, 15);
        in_valid <= 1'b0;
      end else begin
        in_data  <= vertex_q.pop_front();
        in_valid <= 1'b1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result stall generator, raising out_stall in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (out_idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: predict on each input transfer, check each result transfer.
  always @(posedge clk) begin
    cycle_count++;
    in_took <= rst_n && in_valid && !in_stall;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count,
               transformed_q.size());
      $display("simulation failed");
      $finish;
    end else if (rst_n) begin
      if (in_valid && !in_stall) begin
        transformed_q.push_back(transform_vertex(in_data));
        accepted_total++;
        if (in_data.point_mode) point_total++;
      end
      if (out_valid && !out_stall) begin
        checked_total++;
        if (transformed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("unexpected result at cycle %0d: x=%h y=%h z=%h w=%h sat=%b",
                     cycle_count, out_data.out_x, out_data.out_y, out_data.out_z,
                     out_data.out_w, out_data.saturated);
          end
        end else begin
          want = transformed_q.pop_front();
          if (want.saturated) sat_total++;
          if (out_data.out_x !== want.out_x || out_data.out_y !== want.out_y ||
              out_data.out_z !== want.out_z || out_data.out_w !== want.out_w ||
              out_data.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) show_mismatch(want, out_data);
          end
        end
      end
    end
  end

  // Stimulus sequence: directed corners, then random matrices and vectors.
  initial begin
    matrix_regs[0] = 64'h0000_0000_0001_0000;
    matrix_regs[1] = 64'h0000_0000_0000_0000;
    matrix_regs[2] = 64'h0001_0000_0000_0000;
    matrix_regs[3] = 64'h0000_0000_0000_0000;
    matrix_regs[4] = 64'h0000_0000_0000_0000;
    matrix_regs[5] = 64'h0000_0000_0001_0000;
    matrix_regs[6] = 64'h0000_0000_0000_0000;
    matrix_regs[7] = 64'h0001_0000_0000_0000;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;

    // Identity matrix out of reset: extremes pass through, point mode zeroes w.
    send(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0);
    send(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
    send(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
    send(Q_ONE, 2 * Q_ONE, -3 * Q_ONE, 32'sh1234_5678, 1'b1);
    send(Q_MIN, Q_MIN, Q_MIN, Q_MAX, 1'b1);
    wait_idle();

    // Extreme rows: saturation both ways, the widest sums and floor rounding.
    set_row(0, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    set_row(1, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    set_row(2, Q_LSB, Q_NEG1, Q_ZERO, Q_ONE);
    set_row(3, Q_MIN, Q_MAX, Q_ONE, Q_NEG1);
    write_cfg(CFG_IDX_W'(NUM_CFG), {$urandom, $urandom});
    write_cfg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), {$urandom, $urandom});
    send(Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b0);
    send(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
    send(Q_LSB, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0);
    send(Q_NEG1, Q_ZERO, Q_ZERO, Q_ZERO, 1'b0);
    send(Q_ZERO, Q_LSB, Q_ZERO, Q_ZERO, 1'b0);
    send(Q_ONE, -Q_ONE, Q_MAX, Q_MIN, 1'b1);
    wait_idle();

    // Only the w row overflows: flagged for a full vector, not for a point.
    set_row(0, Q_ONE, Q_ZERO, Q_ZERO, Q_ZERO);
    set_row(1, Q_ZERO, Q_ONE, Q_ZERO, Q_ZERO);
    set_row(2, Q_ZERO, Q_ZERO, Q_ONE, Q_ZERO);
    set_row(3, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    send(Q_MAX, Q_MAX, Q_MAX, Q_ZERO, 1'b1);
    send(Q_MAX, Q_MAX, Q_MAX, Q_ZERO, 1'b0);
    send(Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
    wait_idle();

    // Random phases, each with a fresh matrix; the last one runs without idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      load_matrix(value_style_e'(p % 4));
      if (p == RANDOM_PHASES - 1) begin
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
      end else begin
        in_idle_on  = $urandom_range(0, 3) != 0;
        out_idle_on = $urandom_range(0, 3) != 0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        value_style_e vs;
        vs = value_style_e'($urandom_range(0, 3));
        send(random_value(vs), random_value(vs), random_value(vs), random_value(vs),
             $urandom_range(0, 2) == 0);
      end
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (transformed_q.size() != 0) begin
      $display("%0d expected results never arrived", transformed_q.size());
      mismatches += transformed_q.size();
    end
    $display("checked %0d vectors (%0d points, %0d saturated), %0d register writes",
             checked_total, point_total, sat_total, cfg_writes);
    $display("%0d of %0d sent vectors accepted, %0d mismatches", accepted_total,
             queued_total, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
